@@ hw/rtl/rdc_pkg.sv @@
// shared types, constants and the digit glyph function for the radix digit converter
package rdc_pkg;

  localparam int unsigned RADIX_W   = 6;
  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned STEP_BITS = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'd55;  // 'A' - 10

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  // glyph for one digit value: 0-9 then A-Z
  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [RADIX_W-1:0] dv);
    logic [CHAR_W-1:0] c;
    if (dv < 6'd10) begin
      c = CHAR_ZERO + {1'b0, dv};
    end else begin
      c = CHAR_LETTER + {1'b0, dv};
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/radix_digit_converter.sv @@
// top level: converts an unsigned value into base-radix ascii digits, least significant first
//
// A request is taken when start is high and busy is low; the low VALUE_BITS bits of in_value are
// converted with the radix held in the configuration register (2 to 36, reset 10; cfg_wr_data
// outside that range is clamped to the nearest end). Digits come out least significant first,
// each on the out_ ports for exactly one cycle with out_valid high; the receiver cannot stall, so
// every strobe must be taken. out_last_digit marks the most significant digit, and a zero value
// gives the single digit '0'. Each digit is produced by one shared restoring divider that handles
// 8 dividend bits per cycle, passing over the whole zero-padded dividend for each digit; a request
// repeats this once per digit. busy drops in the cycle the last digit is shown, and a new request
// may be taken in that same cycle. Write the radix only while idle.
module radix_digit_converter
  import rdc_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  output logic [CHAR_W-1:0]     out_digit_char,
  output logic [RADIX_W-1:0]    out_digit_value,
  output logic                  out_last_digit,
  input  logic                  cfg_wr_en,
  input  logic [RADIX_W-1:0]    cfg_wr_data
);

  localparam int unsigned STEPS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned WORK_W = STEPS * STEP_BITS;
  localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

  state_t              state_r, state_nxt;
  logic [WORK_W-1:0]   work_r, work_nxt;
  logic [RADIX_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [RADIX_W-1:0]  radix_r, radix_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic [RADIX_W-1:0]  out_dv_r, out_dv_nxt;
  logic                out_last_r, out_last_nxt;

  // shared divide step: eight restoring compare-subtract steps on the running remainder
  logic [RADIX_W-1:0]        step_rem;
  logic [STEP_BITS-1:0]      step_q;
  logic [WORK_W+STEP_BITS-1:0] step_cat;
  logic [WORK_W-1:0]         step_work;

  always_comb begin
    logic [RADIX_W:0] trial;
    logic [RADIX_W-1:0] r;
    r = rem_r;
    step_q = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {r, work_r[WORK_W-1-i]};
      if (trial >= {1'b0, radix_r}) begin
        trial = trial - {1'b0, radix_r};
        step_q[STEP_BITS-1-i] = 1'b1;
      end
      r = trial[RADIX_W-1:0];
    end
    step_rem  = r;
    step_cat  = {work_r, step_q};
    step_work = step_cat[WORK_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    radix_nxt     = radix_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_dv_nxt    = out_dv_r;
    out_last_nxt  = out_last_r;

    if (cfg_wr_en) begin
      if (cfg_wr_data < RADIX_MIN) begin
        radix_nxt = RADIX_MIN;
      end else if (cfg_wr_data > RADIX_MAX) begin
        radix_nxt = RADIX_MAX;
      end else begin
        radix_nxt = cfg_wr_data;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          work_nxt  = WORK_W'(in_value);
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        work_nxt = step_work;
        rem_nxt  = step_rem;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          // quotient complete: show the remainder as this digit
          out_valid_nxt = 1'b1;
          out_dv_nxt    = step_rem;
          out_char_nxt  = digit_glyph(step_rem);
          out_last_nxt  = (step_work == '0);
          rem_nxt       = '0;
          cnt_nxt       = '0;
          if (step_work == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radix_r     <= RADIX_RESET;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      radix_r     <= radix_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    out_char_r <= out_char_nxt;
    out_dv_r   <= out_dv_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_digit_char  = out_char_r;
  assign out_digit_value = out_dv_r;
  assign out_last_digit  = out_last_r;

endmodule

@@ hw/rtl/rdc_checker.sv @@
// port-level checks for the radix digit converter, bound to the top level
module rdc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [6:0] out_digit_char,
  input logic [5:0] out_digit_value,
  input logic       out_last_digit
);

  // a taken request keeps the block busy until its digits are out
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // glyph matches the digit value
  a_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_digit_value < 6'd10 &&
                    out_digit_char == 7'd48 + {1'b0, out_digit_value}) ||
                   (out_digit_value >= 6'd10 && out_digit_value < 6'd36 &&
                    out_digit_char == 7'd55 + {1'b0, out_digit_value})))
    else $error("digit character does not match digit value");

  // the final digit ends the request, earlier digits leave it running
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_digit) |-> !busy)
    else $error("still busy on final digit");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_digit) |-> busy)
    else $error("idle before final digit");

  a_fall_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid && out_last_digit))
    else $error("busy dropped without a final digit");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_digit_char  (out_digit_char),
  .out_digit_value (out_digit_value),
  .out_last_digit  (out_last_digit)
);
